// ----- src/fccr_pkg.sv -----
// Shared types, codes and constants of the clock replacement frame table.
`timescale 1ns / 1ps
`default_nettype none

package fccr_pkg;

	localparam int FRAMES_DEF    = 256;
	localparam int PIN_WIDTH_DEF = 16;

	localparam int FC_W   = 9;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [FC_W-1:0] FRAME_COUNT_RESET = 9'd256;
	localparam logic [0:0]      REG_FRAME_COUNT   = 1'b0;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_PIN   = 2'd1;
	localparam logic [1:0] OP_UNPIN = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_VICTIM = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] frame_index;
	} in_item_t;

	typedef struct packed {
		logic [7:0] result_frame;
		logic [1:0] status;
		logic       evicted;
		logic       released;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SWEEP_RD,
		S_SWEEP_EVAL,
		S_UPDATE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic alloc_fill;
		logic sweep_start;
		logic sweep_read;
		logic sweep_eval;
		logic pin_read;
		logic pin_update;
		logic set_range;
		logic set_fail;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       filling;
		logic       in_range;
		logic       sweep_done;
		logic       victim;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- src/fccr_ctrl.sv -----
// Controller state machine that sequences allocate, pin and unpin transactions.
`timescale 1ns / 1ps
`default_nettype none

module fccr_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  fccr_pkg::sts_t   sts,
	output fccr_pkg::cmd_t   cmd
);
	import fccr_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_stall   = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.opcode)
					OP_ALLOC: begin
						if (sts.filling) begin
							cmd.alloc_fill = 1'b1;
							state_next     = S_FINISH;
						end else begin
							cmd.sweep_start = 1'b1;
							state_next      = S_SWEEP_RD;
						end
					end
					OP_PIN, OP_UNPIN: begin
						if (sts.in_range) begin
							cmd.pin_read = 1'b1;
							state_next   = S_UPDATE;
						end else begin
							cmd.set_range = 1'b1;
							state_next    = S_FINISH;
						end
					end
					default: begin
						state_next = S_FINISH;
					end
				endcase
			end
			S_SWEEP_RD: begin
				if (sts.sweep_done) begin
					cmd.set_fail = 1'b1;
					state_next   = S_FINISH;
				end else begin
					cmd.sweep_read = 1'b1;
					state_next     = S_SWEEP_EVAL;
				end
			end
			S_SWEEP_EVAL: begin
				cmd.sweep_eval = 1'b1;
				state_next     = sts.victim ? S_FINISH : S_SWEEP_RD;
			end
			S_UPDATE: begin
				cmd.pin_update = 1'b1;
				state_next     = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/fccr_dpath.sv -----
// Datapath with the frame memory, clock hand, fill count and result register.
`timescale 1ns / 1ps
`default_nettype none

module fccr_dpath #(
	parameter int FRAMES    = fccr_pkg::FRAMES_DEF,
	parameter int PIN_WIDTH = fccr_pkg::PIN_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  fccr_pkg::in_item_t           in_data,
	input  wire                          out_stall,
	output logic                         out_valid,
	output fccr_pkg::out_item_t          out_data,
	input  wire                          cfg_we,
	input  wire [fccr_pkg::FC_W-1:0]     cfg_wdata,
	output logic [fccr_pkg::FC_W-1:0]    frame_count,
	input  fccr_pkg::cmd_t               cmd,
	output fccr_pkg::sts_t               sts
);
	import fccr_pkg::*;

	localparam int AW = $clog2(FRAMES);
	localparam int CW = (AW + 1 > FC_W) ? AW + 1 : FC_W;
	localparam logic [CW-1:0]        FRAMES_C = CW'(FRAMES);
	localparam logic [PIN_WIDTH-1:0] PIN_MAX  = '1;
	localparam logic [PIN_WIDTH-1:0] PIN_ONE  = PIN_WIDTH'(1);

	logic [FC_W-1:0]      frame_count_q;
	logic [CW-1:0]        fill_q;
	logic [CW-1:0]        hand_q;
	logic [CW:0]          visits_q;
	logic                 out_valid_q;
	in_item_t             item_q;
	out_item_t            res_q;
	out_item_t            out_q;

	logic [PIN_WIDTH:0]   mem [FRAMES];
	logic [PIN_WIDTH:0]   rd_data_q;
	logic [AW-1:0]        rd_addr;
	logic                 rd_en;
	logic [AW-1:0]        wr_addr;
	logic [PIN_WIDTH:0]   wr_data;
	logic                 wr_en;

	logic [CW-1:0]        n_act;
	logic [CW-1:0]        idx_ext;
	logic [CW-1:0]        hand_inc;
	logic [CW-1:0]        hand_next;
	logic                 rd_ref;
	logic [PIN_WIDTH-1:0] rd_pin;
	logic [PIN_WIDTH-1:0] new_pin;
	logic                 victim;
	logic                 filling;

	always_comb begin
		if (frame_count_q == '0) begin
			n_act = CW'(1);
		end else if (CW'(frame_count_q) > FRAMES_C) begin
			n_act = FRAMES_C;
		end else begin
			n_act = CW'(frame_count_q);
		end
	end

	assign idx_ext   = CW'(item_q.frame_index);
	assign hand_inc  = hand_q + CW'(1);
	assign hand_next = (hand_inc >= n_act) ? '0 : hand_inc;
	assign rd_ref    = rd_data_q[PIN_WIDTH];
	assign rd_pin    = rd_data_q[PIN_WIDTH-1:0];
	assign victim    = !rd_ref && (rd_pin == '0);
	assign filling   = (fill_q < n_act);

	always_comb begin
		if (item_q.opcode == OP_PIN) begin
			new_pin = (rd_pin != PIN_MAX) ? rd_pin + PIN_ONE : rd_pin;
		end else begin
			new_pin = (rd_pin != '0) ? rd_pin - PIN_ONE : rd_pin;
		end
	end

	assign rd_en   = cmd.pin_read || cmd.sweep_read;
	assign rd_addr = cmd.pin_read ? idx_ext[AW-1:0] : hand_q[AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q[AW-1:0];
		wr_data = {1'b0, PIN_ONE};
		if (cmd.alloc_fill) begin
			wr_en = 1'b1;
		end
		if (cmd.sweep_eval) begin
			wr_en   = 1'b1;
			wr_addr = hand_q[AW-1:0];
			wr_data = victim ? {1'b0, PIN_ONE} : {1'b0, rd_pin};
		end
		if (cmd.pin_update) begin
			wr_en   = 1'b1;
			wr_addr = idx_ext[AW-1:0];
			wr_data = {(item_q.opcode == OP_PIN) ? 1'b1 : rd_ref, new_pin};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
			fill_q        <= '0;
			hand_q        <= '0;
			visits_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_count_q <= cfg_wdata;
			end
			if (cmd.alloc_fill) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.sweep_start) begin
				visits_q <= '0;
				if (hand_q >= n_act) begin
					hand_q <= '0;
				end
			end
			if (cmd.sweep_eval) begin
				hand_q   <= hand_next;
				visits_q <= visits_q + (CW+1)'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q             <= in_data;
			res_q.result_frame <= in_data.frame_index;
			res_q.status       <= ST_OK;
			res_q.evicted      <= 1'b0;
			res_q.released     <= 1'b0;
		end
		if (cmd.alloc_fill) begin
			res_q.result_frame <= fill_q[7:0];
		end
		if (cmd.sweep_eval && victim) begin
			res_q.result_frame <= hand_q[7:0];
			res_q.evicted      <= 1'b1;
		end
		if (cmd.set_fail) begin
			res_q.result_frame <= '0;
			res_q.status       <= ST_NO_VICTIM;
		end
		if (cmd.set_range) begin
			res_q.status <= ST_RANGE;
		end
		if (cmd.pin_update && (item_q.opcode == OP_UNPIN)) begin
			res_q.released <= (rd_pin == PIN_ONE);
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign frame_count = frame_count_q;

	assign sts.opcode     = item_q.opcode;
	assign sts.filling    = filling;
	assign sts.in_range   = (idx_ext < fill_q) && (idx_ext < n_act);
	assign sts.sweep_done = (visits_q == {n_act, 1'b0});
	assign sts.victim     = victim;
	assign sts.out_free   = !out_valid_q || !out_stall;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FRAMES_C)
		else $error("Fill count ran past the frame table depth.");

	a_hand_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hand_q < FRAMES_C)
		else $error("Clock hand points outside the frame table.");

	a_sweep_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_eval |-> !filling)
		else $error("Sweep ran while the table was still filling.");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_fill |=> fill_q == $past(fill_q) + CW'(1))
		else $error("Fill allocation did not advance the fill count.");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("Result register overwritten while a transaction was pending.");

endmodule

`default_nettype wire

// ----- src/frame_cache_clock_replacement.sv -----
// Top level of the frame table with clock (second chance) replacement.
`timescale 1ns / 1ps
`default_nettype none

// Allocate hands out frames in order while the table fills, then sweeps with the clock hand,
// clearing reference bits until it finds an unreferenced, unpinned frame; pin and unpin adjust a
// frame's pin count. One transaction is in work at a time. A sweeping allocate reads and then
// writes the frame memory for each frame it visits. A sweep that finds no victim visits twice
// the active frame count and then returns a no-victim status. A finished result waits in an
// output register, so the next transaction is accepted while it is still stalled.
module frame_cache_clock_replacement #(
	parameter int FRAMES    = fccr_pkg::FRAMES_DEF,
	parameter int PIN_WIDTH = fccr_pkg::PIN_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  fccr_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  wire                              out_stall,
	output fccr_pkg::out_item_t              out_data,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [fccr_pkg::ADDR_W-1:0]       paddr,
	input  wire [fccr_pkg::DATA_W-1:0]       pwdata,
	output logic [fccr_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import fccr_pkg::*;

	cmd_t            cmd;
	sts_t            sts;
	logic            cfg_we;
	logic [FC_W-1:0] frame_count;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_FRAME_COUNT);
	assign prdata = (paddr[ADDR_W-1:2] == REG_FRAME_COUNT) ? DATA_W'(frame_count) : '0;

	fccr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fccr_dpath #(
		.FRAMES    (FRAMES),
		.PIN_WIDTH (PIN_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata[FC_W-1:0]),
		.frame_count (frame_count),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

`default_nettype wire

// ----- verif/tb_frame_cache_clock_replacement.sv -----
// Self-checking testbench for the clock replacement frame table.
`timescale 1ns / 1ps

module tb_frame_cache_clock_replacement;
	import fccr_pkg::*;

	localparam int FRAMES     = FRAMES_DEF;
	localparam int PIN_W      = PIN_WIDTH_DEF;
	localparam int LIMIT      = 4000000;
	localparam int MAX_REPORT = 10;
	localparam int PHASES     = 8;
	localparam int DIR_ROWS   = 25;

	localparam logic [1:0]        OP_NONE = 2'd3;
	localparam logic [ADDR_W-1:0] FC_ADDR = ADDR_W'(4 * REG_FRAME_COUNT);

	typedef enum logic {ROW_XFER, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  op;
		logic [7:0]  idx;
		logic [16:0] reps;
		logic        known;
		out_item_t   want;
		logic [8:0]  cfg;
	} stim_row_t;

	localparam out_item_t NO_WANT = '0;

	// Rows with known set carry a result that follows directly from the state at that point.
	localparam stim_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_XFER,  OP_PIN,   8'h00, 17'd1,     1'b1, '{8'h00, ST_RANGE, 1'b0, 1'b0}, 9'd0},
		'{ROW_XFER,  OP_UNPIN, 8'hFF, 17'd1,     1'b1, '{8'hFF, ST_RANGE, 1'b0, 1'b0}, 9'd0},
		'{ROW_XFER,  OP_NONE,  8'hAA, 17'd1,     1'b1, '{8'hAA, ST_OK, 1'b0, 1'b0},    9'd0},
		'{ROW_XFER,  OP_ALLOC, 8'h55, 17'd1,     1'b1, '{8'h00, ST_OK, 1'b0, 1'b0},    9'd0},
		'{ROW_XFER,  OP_ALLOC, 8'hFF, 17'd1,     1'b1, '{8'h01, ST_OK, 1'b0, 1'b0},    9'd0},
		'{ROW_WRITE, OP_ALLOC, 8'h00, 17'd0,     1'b0, NO_WANT,                        9'd2},
		'{ROW_XFER,  OP_ALLOC, 8'h00, 17'd1,     1'b1, '{8'h00, ST_NO_VICTIM, 1'b0, 1'b0},
			9'd0},
		'{ROW_XFER,  OP_UNPIN, 8'h00, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_UNPIN, 8'h00, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_PIN,   8'h02, 17'd1,     1'b1, '{8'h02, ST_RANGE, 1'b0, 1'b0}, 9'd0},
		'{ROW_XFER,  OP_ALLOC, 8'h00, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_UNPIN, 8'h01, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_PIN,   8'h01, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_UNPIN, 8'h01, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_ALLOC, 8'h00, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_WRITE, OP_ALLOC, 8'h00, 17'd0,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_UNPIN, 8'h00, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_ALLOC, 8'h00, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_PIN,   8'h01, 17'd1,     1'b1, '{8'h01, ST_RANGE, 1'b0, 1'b0}, 9'd0},
		'{ROW_WRITE, OP_ALLOC, 8'h00, 17'd0,     1'b0, NO_WANT,                        9'd511},
		'{ROW_XFER,  OP_ALLOC, 8'h00, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_PIN,   8'h02, 17'd24,    1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_UNPIN, 8'h02, 17'd1,     1'b0, NO_WANT,                        9'd0},
		'{ROW_XFER,  OP_PIN,   8'h03, 17'd1,     1'b1, '{8'h03, ST_RANGE, 1'b0, 1'b0}, 9'd0},
		'{ROW_XFER,  OP_NONE,  8'h55, 17'd1,     1'b1, '{8'h55, ST_OK, 1'b0, 1'b0},    9'd0}
	};

	localparam int PLAN_COUNT [PHASES] = '{4, 1, 3, 8, 2, 256, 0, 16};
	localparam int PLAN_ITEMS [PHASES] = '{60, 30, 50, 60, 40, 60, 30, 70};

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              in_valid  = 1'b0;
	in_item_t          in_data   = '0;
	logic              out_stall = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic              in_stall;
	logic              out_valid;
	out_item_t         out_data;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Shadow copy of the frame table.
	logic [8:0]       fc_setting;
	logic [8:0]       fill_level;
	logic [7:0]       sweep_pos;
	bit               ref_bit [FRAMES];
	logic [PIN_W-1:0] pin_cnt [FRAMES];

	out_item_t frame_replies [$];
	int        mismatches = 0;
	int        cycles     = 0;
	int        xfers_sent = 0;
	int        evictions  = 0;
	int        no_victims = 0;
	int        releases   = 0;
	logic      rx_quiet   = 1'b0;
	int        rx_left    = 0;

	frame_cache_clock_replacement DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles,
				frame_replies.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic out_item_t apply_frame_op(in_item_t it);
		out_item_t r;
		int        n;
		int        lim;
		int        visits;
		logic [7:0] h;
		bit        found;
		n = (fc_setting == 0) ? 1 : (fc_setting > FRAMES) ? FRAMES : int'(fc_setting);
		r.result_frame = it.frame_index;
		r.status       = ST_OK;
		r.evicted      = 1'b0;
		r.released     = 1'b0;
		h              = '0;
		found          = 1'b0;
		case (it.opcode)
			OP_ALLOC: begin
				if (int'(fill_level) < n) begin
					r.result_frame      = fill_level[7:0];
					ref_bit[fill_level] = 1'b0;
					pin_cnt[fill_level] = 1;
					fill_level          = fill_level + 1'b1;
				end else begin
					if (int'(sweep_pos) >= n)
						sweep_pos = '0;
					for (visits = 0; visits < 2 * n && !found; visits++) begin
						h         = sweep_pos;
						sweep_pos = (int'(h) + 1 >= n) ? 8'd0 : h + 8'd1;
						if (!ref_bit[h] && pin_cnt[h] == 0)
							found = 1'b1;
						else
							ref_bit[h] = 1'b0;
					end
					if (found) begin
						r.result_frame = h;
						r.evicted      = 1'b1;
						ref_bit[h]     = 1'b0;
						pin_cnt[h]     = 1;
						evictions++;
					end else begin
						r.result_frame = '0;
						r.status       = ST_NO_VICTIM;
						no_victims++;
					end
				end
			end
			OP_PIN, OP_UNPIN: begin
				lim = (int'(fill_level) < n) ? int'(fill_level) : n;
				if (int'(it.frame_index) >= lim) begin
					r.status = ST_RANGE;
				end else if (it.opcode == OP_PIN) begin
					if (pin_cnt[it.frame_index] != '1)
						pin_cnt[it.frame_index] = pin_cnt[it.frame_index] + 1'b1;
					ref_bit[it.frame_index] = 1'b1;
				end else if (pin_cnt[it.frame_index] != 0) begin
					pin_cnt[it.frame_index] = pin_cnt[it.frame_index] - 1'b1;
					if (pin_cnt[it.frame_index] == 0) begin
						r.released = 1'b1;
						releases++;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic in_item_t pick_frame_op();
		in_item_t it;
		int       r;
		int       n;
		int       lim;
		n   = (fc_setting == 0) ? 1 : (fc_setting > FRAMES) ? FRAMES : int'(fc_setting);
		lim = (int'(fill_level) < n) ? int'(fill_level) : n;
		r   = $urandom_range(0, 99);
		it.frame_index = 8'($urandom_range(0, 255));
		if (r < 5)
			it.opcode = OP_NONE;
		else if (r < 35)
			it.opcode = OP_ALLOC;
		else if (r < 60)
			it.opcode = OP_PIN;
		else
			it.opcode = OP_UNPIN;
		if ((it.opcode == OP_PIN || it.opcode == OP_UNPIN) && lim > 0
				&& $urandom_range(0, 99) < 80)
			it.frame_index = 8'($urandom_range(0, lim - 1));
		return it;
	endfunction

	task automatic send_xfer(in_item_t it, int gap, logic known, out_item_t want);
		out_item_t pred;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (in_stall);
		pred = apply_frame_op(it);
		frame_replies.push_back(known ? want : pred);
		xfers_sent++;
	endtask

	task automatic drain_replies(int extra);
		in_valid <= 1'b0;
		while (frame_replies.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_frame_count(logic [8:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= FC_ADDR;
		pwdata  <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		fc_setting = value;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[8:0] !== value) begin
			mismatches++;
			if (mismatches <= MAX_REPORT)
				$display("frame_count readback: expected %0d, got %0d", value, prdata[8:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : result_check
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_left   <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (frame_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORT)
						$display("Result frame %0d status %0d with no transaction outstanding",
							out_data.result_frame, out_data.status);
				end else begin
					want = frame_replies.pop_front();
					if (out_data.result_frame !== want.result_frame
							|| out_data.status !== want.status
							|| out_data.evicted !== want.evicted
							|| out_data.released !== want.released) begin
						mismatches++;
						if (mismatches <= MAX_REPORT)
							$display({"Mismatch at %0t: expected frame %0d status %0d ",
								"evicted %b released %b, got frame %0d status %0d ",
								"evicted %b released %b"}, $realtime,
								want.result_frame, want.status, want.evicted, want.released,
								out_data.result_frame, out_data.status, out_data.evicted,
								out_data.released);
					end
				end
			end
			if (rx_quiet) begin
				out_stall <= 1'b0;
			end else if (rx_left != 0) begin
				rx_left <= rx_left - 1;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				rx_left   <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 3);
			end
		end
	end

	initial begin : stimulus
		int        r;
		int        k;
		int        p;
		stim_row_t row;
		in_item_t  it;
		fc_setting = FRAME_COUNT_RESET;
		fill_level = '0;
		sweep_pos  = '0;
		for (k = 0; k < FRAMES; k++) begin
			ref_bit[k] = 1'b0;
			pin_cnt[k] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIR_ROWS; r++) begin
			row = DIRECTED[r];
			if (row.kind == ROW_WRITE) begin
				drain_replies(4);
				write_frame_count(row.cfg);
			end else begin
				// A pin burst runs back to back while the receiver never stalls.
				rx_quiet <= (row.reps > 1);
				it.opcode      = row.op;
				it.frame_index = row.idx;
				for (k = 0; k < int'(row.reps); k++)
					send_xfer(it, (row.reps > 1) ? 0 : pick_gap(), row.known, row.want);
			end
		end
		drain_replies(4);
		rx_quiet <= 1'b0;

		for (p = 0; p < PHASES; p++) begin
			drain_replies(4);
			write_frame_count(9'(PLAN_COUNT[p]));
			for (k = 0; k < PLAN_ITEMS[p]; k++) begin
				if ($urandom_range(0, 49) == 0)
					drain_replies(0);
				send_xfer(pick_frame_op(), pick_gap(), 1'b0, NO_WANT);
			end
		end

		drain_replies(20);
		if (frame_replies.size() != 0)
			mismatches++;
		$display("Ran %0d transactions across %0d frame_count settings.", xfers_sent,
			PHASES + 3);
		$display("Saw %0d evictions, %0d sweeps without a victim and %0d releases.",
			evictions, no_victims, releases);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- frame_cache_clock_replacement.f -----
src/fccr_pkg.sv
src/fccr_ctrl.sv
src/fccr_dpath.sv
src/frame_cache_clock_replacement.sv
verif/tb_frame_cache_clock_replacement.sv
